### rtl/et_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// et_pkg
// Shared types and constants of the expression tokenizer.
// ----------------------------------------------------------------------------
package et_pkg;

    localparam int POS_W      = 16;               // offset counter width, 8..32
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        KIND_NUM    = 4'd0,
        KIND_STR    = 4'd1,
        KIND_IDENT  = 4'd2,
        KIND_LPAREN = 4'd3,
        KIND_RPAREN = 4'd4,
        KIND_COMMA  = 4'd5,
        KIND_OP     = 4'd6,
        KIND_END    = 4'd7,
        KIND_ERROR  = 4'd8
    } kind_t;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_LT  = 4'd4,
        OP_GT  = 4'd5,
        OP_NOT = 4'd6,
        OP_DOT = 4'd7,
        OP_AND = 4'd8,
        OP_OR  = 4'd9,
        OP_EQ  = 4'd10,
        OP_NE  = 4'd11,
        OP_LE  = 4'd12,
        OP_GE  = 4'd13
    } op_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_BAD_NUM  = 3'd1,
        ERR_UNCLOSED = 3'd2,
        ERR_ILLEGAL  = 3'd3,
        ERR_TOO_LONG = 3'd4
    } err_t;

    typedef struct packed {
        kind_t       kind;
        op_t         op_code;
        logic [15:0] tok_start;
        logic [15:0] tok_length;
        err_t        error_code;
        logic        last;
    } tok_t;

    // Tokens produced by one accepted character, in order.
    typedef struct packed {
        logic [1:0] count;
        tok_t       tok0;
        tok_t       tok1;
    } scan_out_t;

endpackage

### rtl/et_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// et_scan
// Lexer state and per-character token decode; up to two tokens per request.
// ----------------------------------------------------------------------------
module et_scan import et_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_accept,
    input  logic [7:0] ch,
    input  logic      eot,
    output scan_out_t result
);

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_NUM   = 3'd1,
        MODE_STR   = 3'd2,
        MODE_IDENT = 3'd3,
        MODE_PEND  = 3'd4,
        MODE_DROP  = 3'd5
    } mode_t;

    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

    mode_t            mode_reg,  mode_next;
    logic [7:0]       quote_reg, quote_next;
    logic [7:0]       pend_reg,  pend_next;
    logic [POS_W-1:0] begin_reg, begin_next;
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [1:0]       dots_reg,  dots_next;

    logic [POS_W-1:0] len;
    logic is_digit, is_alpha, is_first, is_next, is_quote, is_pair_lead;
    logic single_ok, pair_ok;
    op_t  single_op, pend_op, pair_op;

    // idle-mode decode of the incoming character
    mode_t id_mode;
    logic  id_emit;
    tok_t  id_tok;

    // close of the token in progress
    logic  cl_emit, cl_ok;
    mode_t cl_mode;
    tok_t  cl_tok;

    tok_t       res [2];
    logic [1:0] n;

    function automatic tok_t mk_tok(kind_t k, op_t o, logic [POS_W-1:0] s,
                                    logic [POS_W-1:0] l, err_t e);
        tok_t t;
        t.kind       = k;
        t.op_code    = o;
        t.tok_start  = 16'(s);
        t.tok_length = 16'(l);
        t.error_code = e;
        t.last       = 1'b0;
        return t;
    endfunction

    function automatic logic single_valid(logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" ||
               c == "<" || c == ">" || c == "!" || c == ".";
    endfunction

    function automatic op_t single_code(logic [7:0] c);
        op_t o;
        unique case (c)
            "-":     o = OP_SUB;
            "*":     o = OP_MUL;
            "/":     o = OP_DIV;
            "<":     o = OP_LT;
            ">":     o = OP_GT;
            "!":     o = OP_NOT;
            ".":     o = OP_DOT;
            default: o = OP_ADD;
        endcase
        return o;
    endfunction

    assign len          = pos_reg - begin_reg;
    assign is_digit     = ch >= "0" && ch <= "9";
    assign is_alpha     = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    assign is_first     = is_alpha || ch == "_";
    assign is_next      = is_first || is_digit;
    assign is_quote     = ch == "'" || ch == "\"";
    assign is_pair_lead = ch == "&" || ch == "|" || ch == "=" ||
                          ch == "!" || ch == "<" || ch == ">";
    assign single_ok    = single_valid(ch);
    assign single_op    = single_code(ch);
    assign pend_op      = single_code(pend_reg);

    // two-character operators
    always_comb begin
        pair_ok = 1'b1;
        pair_op = OP_AND;
        priority if (pend_reg == "&" && ch == "&") pair_op = OP_AND;
        else if (pend_reg == "|" && ch == "|")     pair_op = OP_OR;
        else if (pend_reg == "=" && ch == "=")     pair_op = OP_EQ;
        else if (pend_reg == "!" && ch == "=")     pair_op = OP_NE;
        else if (pend_reg == "<" && ch == "=")     pair_op = OP_LE;
        else if (pend_reg == ">" && ch == "=")     pair_op = OP_GE;
        else                                       pair_ok = 1'b0;
    end

    always_comb begin
        id_mode = MODE_IDLE;
        id_emit = 1'b0;
        id_tok  = mk_tok(KIND_OP, OP_ADD, pos_reg, POS_ONE, ERR_NONE);
        priority if (ch == " ") begin
            id_mode = MODE_IDLE;
        end else if (is_digit) begin
            id_mode = MODE_NUM;
        end else if (is_quote) begin
            id_mode = MODE_STR;
        end else if (is_first) begin
            id_mode = MODE_IDENT;
        end else if (ch == "(") begin
            id_emit = 1'b1;
            id_tok  = mk_tok(KIND_LPAREN, OP_ADD, pos_reg, POS_ONE, ERR_NONE);
        end else if (ch == ")") begin
            id_emit = 1'b1;
            id_tok  = mk_tok(KIND_RPAREN, OP_ADD, pos_reg, POS_ONE, ERR_NONE);
        end else if (ch == ",") begin
            id_emit = 1'b1;
            id_tok  = mk_tok(KIND_COMMA, OP_ADD, pos_reg, POS_ONE, ERR_NONE);
        end else if (is_pair_lead) begin
            id_mode = MODE_PEND;
        end else if (single_ok) begin
            id_emit = 1'b1;
            id_tok  = mk_tok(KIND_OP, single_op, pos_reg, POS_ONE, ERR_NONE);
        end else begin
            id_mode = MODE_DROP;
            id_emit = 1'b1;
            id_tok  = mk_tok(KIND_ERROR, OP_ADD, pos_reg, POS_ONE, ERR_ILLEGAL);
        end
    end

    always_comb begin
        cl_emit = 1'b0;
        cl_ok   = 1'b1;
        cl_mode = MODE_IDLE;
        cl_tok  = mk_tok(KIND_NUM, OP_ADD, begin_reg, len, ERR_NONE);
        unique case (mode_reg)
            MODE_NUM: begin
                cl_emit = 1'b1;
                if (dots_reg > 2'd1) begin
                    cl_ok   = 1'b0;
                    cl_mode = MODE_DROP;
                    cl_tok  = mk_tok(KIND_ERROR, OP_ADD, begin_reg, len, ERR_BAD_NUM);
                end
            end
            MODE_IDENT: begin
                cl_emit = 1'b1;
                cl_tok  = mk_tok(KIND_IDENT, OP_ADD, begin_reg, len, ERR_NONE);
            end
            MODE_PEND: begin
                cl_emit = 1'b1;
                if (single_valid(pend_reg)) begin
                    cl_tok = mk_tok(KIND_OP, pend_op, begin_reg, POS_ONE, ERR_NONE);
                end else begin
                    cl_ok   = 1'b0;
                    cl_mode = MODE_DROP;
                    cl_tok  = mk_tok(KIND_ERROR, OP_ADD, begin_reg, POS_ONE, ERR_ILLEGAL);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        logic run_idle;
        logic do_close;
        run_idle   = 1'b0;
        do_close   = 1'b0;
        mode_next  = mode_reg;
        quote_next = quote_reg;
        pend_next  = pend_reg;
        begin_next = begin_reg;
        pos_next   = pos_reg;
        dots_next  = dots_reg;
        res[0]     = '0;
        res[1]     = '0;
        n          = 2'd0;

        if (eot) begin
            if (mode_reg == MODE_STR) begin
                res[0] = mk_tok(KIND_ERROR, OP_ADD, begin_reg, len, ERR_UNCLOSED);
                n      = 2'd1;
            end else if (mode_reg != MODE_DROP) begin
                if (cl_emit) begin
                    res[0] = cl_tok;
                    n      = 2'd1;
                end
                if (cl_ok) begin
                    res[n[0]] = mk_tok(KIND_END, OP_ADD, pos_reg, '0, ERR_NONE);
                    n         = n + 2'd1;
                end
            end
            mode_next  = MODE_IDLE;
            quote_next = '0;
            pend_next  = '0;
            begin_next = '0;
            pos_next   = '0;
            dots_next  = '0;
        end else if (mode_reg == MODE_DROP) begin
            mode_next = MODE_DROP;
        end else if (pos_reg == POS_MAX) begin
            res[0]    = mk_tok(KIND_ERROR, OP_ADD, pos_reg, '0, ERR_TOO_LONG);
            n         = 2'd1;
            mode_next = MODE_DROP;
        end else begin
            unique case (mode_reg)
                MODE_NUM: begin
                    if (ch == ".") begin
                        if (dots_reg < 2'd2) dots_next = dots_reg + 2'd1;
                    end else if (!is_digit) begin
                        do_close = 1'b1;
                    end
                end
                MODE_STR: begin
                    if (ch == quote_reg) begin
                        res[0]    = mk_tok(KIND_STR, OP_ADD, begin_reg, len, ERR_NONE);
                        n         = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_IDENT: begin
                    do_close = !is_next;
                end
                MODE_PEND: begin
                    if (pair_ok) begin
                        res[0]    = mk_tok(KIND_OP, pair_op, begin_reg, POS_W'(2), ERR_NONE);
                        n         = 2'd1;
                        mode_next = MODE_IDLE;
                    end else begin
                        do_close = 1'b1;
                    end
                end
                default: begin
                    run_idle = 1'b1;
                end
            endcase

            if (do_close) begin
                res[0]    = cl_tok;
                n         = 2'd1;
                mode_next = cl_mode;
                run_idle  = cl_ok;
            end

            if (run_idle) begin
                mode_next = id_mode;
                unique case (id_mode)
                    MODE_NUM: begin
                        begin_next = pos_reg;
                        dots_next  = '0;
                    end
                    MODE_STR: begin
                        quote_next = ch;
                        begin_next = pos_reg + POS_ONE;
                    end
                    MODE_IDENT: begin
                        begin_next = pos_reg;
                    end
                    MODE_PEND: begin
                        pend_next  = ch;
                        begin_next = pos_reg;
                    end
                    default: begin
                    end
                endcase
                if (id_emit) begin
                    res[n[0]] = id_tok;
                    n         = n + 2'd1;
                end
            end
            pos_next = pos_reg + POS_ONE;
        end

        // final token of this character
        if (n == 2'd2) begin
            res[1].last = 1'b1;
        end else if (n == 2'd1) begin
            res[0].last = 1'b1;
        end
    end

    assign result.count = in_accept ? n : 2'd0;
    assign result.tok0  = res[0];
    assign result.tok1  = res[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            quote_reg <= '0;
            pend_reg  <= '0;
            begin_reg <= '0;
            pos_reg   <= '0;
            dots_reg  <= '0;
        end else if (in_accept) begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            pend_reg  <= pend_next;
            begin_reg <= begin_next;
            pos_reg   <= pos_next;
            dots_reg  <= dots_next;
        end
    end

endmodule

### rtl/et_tok_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// et_tok_fifo
// Small token queue: takes up to two tokens per cycle, gives one.
// ----------------------------------------------------------------------------
module et_tok_fifo import et_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  scan_out_t push,
    input  logic      pop,
    output logic      out_valid,
    output tok_t      head,
    output logic      room
);

    tok_t               q_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               do_pop;

    assign out_valid = count_reg != '0;
    assign head      = q_reg[rd_ptr_reg];
    assign do_pop    = pop && out_valid;
    // room for a full pair of tokens
    assign room      = count_reg <= FIFO_CW'(FIFO_DEPTH - 2);

    always_comb begin
        count_next = count_reg + FIFO_CW'(push.count) - FIFO_CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) q_reg[wr_ptr_reg] <= push.tok0;
        if (push.count == 2'd2) q_reg[wr_ptr_reg + FIFO_AW'(1)] <= push.tok1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push.count);
            if (do_pop) rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/expression_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_tokenizer
// Streaming lexer: one character per request in, tokens out.
// ----------------------------------------------------------------------------
// Characters of an expression arrive one per input request (s_tuser high
// marks end of text and carries no character). Each token leaves as kind
// (m_tuser), operator code, start offset, length and error code, with m_tlast
// on the final token a request caused. A request is taken every cycle as long
// as the four-entry token queue has room for two tokens; the queue drains one
// token per cycle while the receiver is ready, so a character that closes one
// token and opens another (two tokens) drains slower than single-token or
// silent characters, which flow at one per cycle under the same conditions.
// Decode happens in the accept cycle and the tokens are registered into the
// queue behind any waiting tokens. No initialization pass after reset. After
// an error the rest of the expression is swallowed until end of text.
// ----------------------------------------------------------------------------
module expression_tokenizer import et_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input characters
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] end_of_text
    // tokens
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] op_code, [19:4] tok_start,
                                   // [35:20] tok_length, [38:36] error_code,
                                   // [39] zero
    output logic [3:0]  m_tuser,   // [3:0] kind
    output logic        m_tlast    // last_of_input
);

    logic      in_accept;
    scan_out_t scan_res;
    tok_t      head;
    logic      room;

    // no request is taken while reset is held
    assign s_tready  = room && aresetn;
    assign in_accept = s_tvalid && s_tready;

    // lexer state, decode of one character into zero, one or two tokens
    et_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .ch        (s_tdata),
        .eot       (s_tuser),
        .result    (scan_res)
    );

    // token queue decouples the two-token case from the output side
    et_tok_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (scan_res),
        .pop       (m_tready),
        .out_valid (m_tvalid),
        .head      (head),
        .room      (room)
    );

    assign m_tdata = {1'b0, head.error_code, head.tok_length, head.tok_start,
                      head.op_code};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

### rtl/et_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// et_checker
// Port-level checks of the expression tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module et_checker import et_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // stalled token holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("token changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("token valid right after reset");

    // End closes its request and has no text
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_END |-> m_tlast && m_tdata[35:20] == 16'd0)
        else $error("malformed End token");

    // an error ends the request and carries a code
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERROR |-> m_tlast && m_tdata[38:36] != 3'd0)
        else $error("malformed error token");

    a_noerr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_ERROR |-> m_tdata[38:36] == 3'd0)
        else $error("error code on a normal token");

endmodule

bind expression_tokenizer et_checker u_et_checker (.*);

### test/tb_expression_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_expression_tokenizer
// Self-checking bench for the streaming expression tokenizer.
// ----------------------------------------------------------------------------
// Characters go in as requests, one per handshake. A scoreboard class keeps a
// private lexer that mirrors the block's scan rules and queues the tokens
// every accepted request should cause. Each token taken on the master side is
// checked field by field against the oldest queued token. Stimulus: a short
// directed set, then random expressions, mostly well-formed with random
// content and some noise.
// Both sides idle at random; the receiver holds off once for a long stretch
// so the token queue fills and the input stalls.
// ----------------------------------------------------------------------------
module tb_expression_tokenizer;
    import et_pkg::*;

    localparam int RANDOM_ITEMS = 520;
    localparam int DEAD_LIMIT   = 2000;   // cycles with no handshake at all
    localparam int LONG_HOLD    = 250;    // receiver hold-off, in cycles
    localparam int TAIL_CYCLES  = 20;

    // ------------------------------------------------------------------------
    // Token scoreboard: predicts tokens per request, checks taken tokens.
    // ------------------------------------------------------------------------
    class token_scoreboard;
        typedef enum logic [2:0] {
            SCAN_IDLE, SCAN_NUM, SCAN_STR, SCAN_IDENT, SCAN_PEND, SCAN_DROP
        } scan_t;

        scan_t            mode;
        logic [7:0]       quote_ch;
        logic [7:0]       pend_ch;
        logic [POS_W-1:0] tok_origin;
        logic [POS_W-1:0] cur_pos;
        logic [1:0]       dots;      // dots in current number, saturates at 2
        tok_t             fresh[$];  // tokens of the request being scanned
        tok_t             expected_q[$];
        int               failures;

        function new();
            failures = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode       = SCAN_IDLE;
            quote_ch   = '0;
            pend_ch    = '0;
            tok_origin = '0;
            cur_pos    = '0;
            dots       = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // op_code is zero (OP_ADD) for every kind but op
        function void emit(kind_t k, op_t code, logic [POS_W-1:0] start,
                           logic [POS_W-1:0] len, err_t e);
            tok_t t;
            t.kind       = k;
            t.op_code    = code;
            t.tok_start  = 16'(start);
            t.tok_length = 16'(len);
            t.error_code = e;
            t.last       = 1'b0;
            fresh.insert(fresh.size(), t);
        endfunction

        function void abort(err_t e, logic [POS_W-1:0] start, logic [POS_W-1:0] len);
            emit(KIND_ERROR, OP_ADD, start, len, e);
            mode = SCAN_DROP;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit ident_first(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        endfunction

        function bit ident_next(logic [7:0] c);
            return ident_first(c) || is_digit(c);
        endfunction

        function bit single_op(logic [7:0] c, output op_t code);
            code = OP_ADD;
            case (c)
                "+": code = OP_ADD;
                "-": code = OP_SUB;
                "*": code = OP_MUL;
                "/": code = OP_DIV;
                "<": code = OP_LT;
                ">": code = OP_GT;
                "!": code = OP_NOT;
                ".": code = OP_DOT;
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function bit pair_op(logic [7:0] a, logic [7:0] b, output op_t code);
            code = OP_ADD;
            case ({a, b})
                "&&": code = OP_AND;
                "||": code = OP_OR;
                "==": code = OP_EQ;
                "!=": code = OP_NE;
                "<=": code = OP_LE;
                ">=": code = OP_GE;
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        // Character seen with no token open.
        function void scan_fresh(logic [7:0] c, logic [POS_W-1:0] pos);
            op_t code;
            mode = SCAN_IDLE;
            if (c == " ") return;
            if (is_digit(c)) begin
                mode       = SCAN_NUM;
                tok_origin = pos;
                dots       = '0;
            end else if (c == "'" || c == "\"") begin
                mode       = SCAN_STR;
                quote_ch   = c;
                tok_origin = pos + 1'b1;   // content starts after the quote
            end else if (ident_first(c)) begin
                mode       = SCAN_IDENT;
                tok_origin = pos;
            end else if (c == "(") begin
                emit(KIND_LPAREN, OP_ADD, pos, POS_W'(1), ERR_NONE);
            end else if (c == ")") begin
                emit(KIND_RPAREN, OP_ADD, pos, POS_W'(1), ERR_NONE);
            end else if (c == ",") begin
                emit(KIND_COMMA, OP_ADD, pos, POS_W'(1), ERR_NONE);
            end else if (c == "&" || c == "|" || c == "=" || c == "!" || c == "<" ||
                         c == ">") begin
                // may pair with the next character
                mode       = SCAN_PEND;
                pend_ch    = c;
                tok_origin = pos;
            end else if (single_op(c, code)) begin
                emit(KIND_OP, code, pos, POS_W'(1), ERR_NONE);
            end else begin
                abort(ERR_ILLEGAL, pos, POS_W'(1));
            end
        endfunction

        // Closes the open token; returns 0 when that ends the expression.
        function bit close_token(logic [POS_W-1:0] pos);
            logic [POS_W-1:0] len;
            op_t              code;
            len = pos - tok_origin;
            case (mode)
                SCAN_NUM: begin
                    if (dots > 2'd1) begin
                        abort(ERR_BAD_NUM, tok_origin, len);
                        return 1'b0;
                    end
                    emit(KIND_NUM, OP_ADD, tok_origin, len, ERR_NONE);
                end
                SCAN_IDENT: emit(KIND_IDENT, OP_ADD, tok_origin, len, ERR_NONE);
                SCAN_PEND: begin
                    // lone & | = are illegal, lone ! < > are plain ops
                    if (!single_op(pend_ch, code)) begin
                        abort(ERR_ILLEGAL, tok_origin, POS_W'(1));
                        return 1'b0;
                    end
                    emit(KIND_OP, code, tok_origin, POS_W'(1), ERR_NONE);
                end
                default: ;
            endcase
            mode = SCAN_IDLE;
            return 1'b1;
        endfunction

        // Accepted request: queue the tokens it causes.
        function void note_request(logic [7:0] c, logic eot);
            logic [POS_W-1:0] pos;
            op_t              code;
            fresh.delete();
            pos = cur_pos;
            if (eot) begin
                if (mode == SCAN_STR) begin
                    emit(KIND_ERROR, OP_ADD, tok_origin, pos - tok_origin, ERR_UNCLOSED);
                end else if (mode != SCAN_DROP) begin
                    if (close_token(pos)) emit(KIND_END, OP_ADD, pos, '0, ERR_NONE);
                end
                clear_state();
            end else if (mode != SCAN_DROP) begin
                if (pos == '1) begin
                    abort(ERR_TOO_LONG, pos, '0);
                end else begin
                    case (mode)
                        SCAN_NUM: begin
                            if (c == ".") begin
                                if (dots < 2'd2) dots++;
                            end else if (!is_digit(c)) begin
                                if (close_token(pos)) scan_fresh(c, pos);
                            end
                        end
                        SCAN_STR: begin
                            if (c == quote_ch) begin
                                emit(KIND_STR, OP_ADD, tok_origin, pos - tok_origin,
                                     ERR_NONE);
                                mode = SCAN_IDLE;
                            end
                        end
                        SCAN_IDENT: begin
                            if (!ident_next(c) && close_token(pos)) scan_fresh(c, pos);
                        end
                        SCAN_PEND: begin
                            if (pair_op(pend_ch, c, code)) begin
                                emit(KIND_OP, code, tok_origin, POS_W'(2), ERR_NONE);
                                mode = SCAN_IDLE;
                            end else if (close_token(pos)) begin
                                scan_fresh(c, pos);
                            end
                        end
                        default: scan_fresh(c, pos);
                    endcase
                    cur_pos = pos + 1'b1;
                end
            end
            if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i]) expected_q.insert(expected_q.size(), fresh[i]);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                failures++;
            end
        endfunction

        // Token taken on the master side.
        function void check_token(logic [39:0] data, logic [3:0] kind, logic last);
            tok_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected token, expected none, actual kind %0d start %0d",
                         $time, kind, data[19:4]);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind", 16'(want.kind), 16'(kind));
            compare_field("op_code", 16'(want.op_code), 16'(data[3:0]));
            compare_field("tok_start", want.tok_start, data[19:4]);
            compare_field("tok_length", want.tok_length, data[35:20]);
            compare_field("error_code", 16'(want.error_code), 16'(data[38:36]));
            compare_field("pad", 16'd0, 16'(data[39]));
            compare_field("last", 16'(want.last), 16'(last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    bit              steady     = 1'b0;   // neither side idles while set
    bit              hold_phase = 1'b0;   // asks the receiver for its long hold
    int              dead_cycles = 0;
    token_scoreboard sb = new();

    always #1 aclk = ~aclk;

    expression_tokenizer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Idle span: zero most of the time, else mostly short, rarely long.
    function automatic int idle_span(int busy_pct);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < busy_pct) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [7:0] c, input logic eot);
        int gap;
        gap = idle_span(55);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= eot;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(c, eot);
    endtask

    // ch is don't-care with end of text, so it gets random bits
    task automatic send_eot();
        send_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
    endtask

    // sender goes quiet until every predicted token has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Append one random lexeme (or a bit of junk) to an expression.
    function automatic void add_token(ref logic [7:0] text[$]);
        string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        string alnum   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        string singles = "+-*/<>!.";
        string pairs   = "&&||==!=<=>=";
        string lone    = "&|=";
        logic [7:0] q;
        logic [7:0] c;
        int         k;
        case ($urandom_range(0, 11))
            0, 1: begin
                // number: digits with 0, 1 or (rarely) 2 dots
                k = $urandom_range(0, 9);
                text.insert(text.size(), 8'("0" + $urandom_range(0, 9)));
                repeat ($urandom_range(0, 3))
                    text.insert(text.size(), 8'("0" + $urandom_range(0, 9)));
                repeat (k < 6 ? 0 : (k < 9 ? 1 : 2)) begin
                    text.insert(text.size(), ".");
                    repeat ($urandom_range(0, 2))
                        text.insert(text.size(), 8'("0" + $urandom_range(0, 9)));
                end
            end
            2: begin
                q = $urandom_range(0, 1) ? "'" : "\"";
                text.insert(text.size(), q);
                repeat ($urandom_range(0, 5)) begin
                    c = 8'($urandom_range(32, 126));
                    text.insert(text.size(), c == q ? 8'("x") : c);
                end
                if ($urandom_range(0, 9) != 0) text.insert(text.size(), q);
            end
            3, 4: begin
                text.insert(text.size(), letters[$urandom_range(0, letters.len() - 1)]);
                repeat ($urandom_range(0, 5))
                    text.insert(text.size(), alnum[$urandom_range(0, alnum.len() - 1)]);
            end
            5: text.insert(text.size(), "(");
            6: text.insert(text.size(), ")");
            7: text.insert(text.size(), ",");
            8: text.insert(text.size(), singles[$urandom_range(0, 7)]);
            9: begin
                k = 2 * $urandom_range(0, 5);
                text.insert(text.size(), pairs[k]);
                text.insert(text.size(), pairs[k + 1]);
            end
            10: begin
                if ($urandom_range(0, 1)) text.insert(text.size(), lone[$urandom_range(0, 2)]);
                else text.insert(text.size(), 8'($urandom_range(0, 255)));
            end
            default: repeat ($urandom_range(1, 3)) text.insert(text.size(), " ");
        endcase
    endfunction

    initial begin
        logic [7:0] text[$];
        int         sent;
        int         expr_idx;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: all token kinds, pair op, bad number, lone '&' with the
        // next char swallowed, unclosed quote, illegal high byte with a NUL after it.
        send_text("(_a9,\"s\")>=1.5");
        send_eot();
        send_text("1..2");
        send_eot();
        send_text("&a");
        send_eot();
        send_text("'ab");
        send_eot();
        send_request(8'hFF, 1'b0);
        send_request(8'h00, 1'b0);
        send_eot();
        wait_drained();

        // Random expressions.
        sent     = 0;
        expr_idx = 0;
        while (sent < RANDOM_ITEMS) begin
            text.delete();
            steady = ($urandom_range(0, 5) == 0);
            if (expr_idx == 5) hold_phase <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8))
                    text.insert(text.size(), 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    add_token(text);
                    if ($urandom_range(0, 1)) text.insert(text.size(), " ");
                end
            end
            foreach (text[i]) send_request(text[i], 1'b0);
            send_eot();
            sent += text.size() + 1;
            expr_idx++;
            // let the receiver catch up now and then
            if (expr_idx % 10 == 0) wait_drained();
        end
        steady = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: checks taken tokens and drives m_tready.
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        bit held_once;
        stall     = 0;
        held_once = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_token(m_tdata, m_tuser, m_tlast);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if (hold_phase && !held_once) begin
                // long hold-off while the sender keeps pushing requests
                held_once = 1'b1;
                stall     = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else begin
                stall = idle_span(65);
                if (stall == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    stall--;
                end
            end
        end
    end

    // Watchdog: gives up when neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            dead_cycles <= 0;
        end else if (aresetn) begin
            if (dead_cycles >= DEAD_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                dead_cycles <= dead_cycles + 1;
            end
        end
    end

endmodule

### expression_tokenizer.f
rtl/et_pkg.sv
rtl/et_scan.sv
rtl/et_tok_fifo.sv
rtl/expression_tokenizer.sv
rtl/et_checker.sv
test/tb_expression_tokenizer.sv
